### design/assert_macros.svh
// Assertion macros used by the radar fall classifier RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a property holds at every clock edge outside reset.
`define RFC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check that a condition never holds at any clock edge outside reset.
`define RFC_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define RFC_ASSERT(lbl, clk, rstn, prop, msg)
`define RFC_ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

### design/rfc_pkg.sv
// Shared constants, codes and types of the radar fall classifier.
`timescale 1ns / 1ps
`default_nettype none

package rfc_pkg;

    // Distance history geometry
    localparam int HIST_DEPTH    = 8;
    localparam int HIST_IDX_W    = $clog2(HIST_DEPTH);
    localparam int HIST_LOOKBACK = 3;
    // Entry read relative to the write slot of the current item
    localparam int HIST_BACK_OFS = HIST_LOOKBACK - 1;

    // Register reset value and fixed limits
    localparam logic [6:0] THRESHOLD_RESET = 7'd70;
    localparam logic [6:0] VERIFY_LEVEL    = 7'd95;
    localparam logic [6:0] SCORE_MAX       = 7'd100;
    localparam logic [6:0] MOVE_MAX        = 7'd100;
    localparam logic [7:0] OCCUPANTS_MAX   = 8'd4;

    // Posture codes
    localparam logic [2:0] POSTURE_ABSENT   = 3'd0;
    localparam logic [2:0] POSTURE_FALLING  = 3'd1;
    localparam logic [2:0] POSTURE_LYING    = 3'd2;
    localparam logic [2:0] POSTURE_STANDING = 3'd3;
    localparam logic [2:0] POSTURE_SITTING  = 3'd4;
    localparam logic [2:0] POSTURE_UNKNOWN  = 3'd5;

    // Mode request codes
    localparam logic [1:0] MODE_NONE     = 2'd0;
    localparam logic [1:0] MODE_POINT    = 2'd1;
    localparam logic [1:0] MODE_PRESENCE = 2'd2;

    // Posture bounds (cm, cm/s)
    localparam logic signed [15:0] VEL_FALLING   = -16'sd150;
    localparam logic signed [15:0] DIST_NEAR     = 16'sd30;
    localparam logic signed [15:0] DIST_SIT_LO   = 16'sd40;
    localparam logic signed [15:0] DIST_MID      = 16'sd80;
    localparam logic signed [15:0] DIST_STAND_HI = 16'sd200;
    localparam logic [15:0]        SPEED_LYING   = 16'd20;
    localparam logic [15:0]        SPEED_SIT     = 16'd30;
    localparam logic [15:0]        SPEED_STAND   = 16'd50;

    // Score bounds and weights
    localparam logic signed [15:0] VEL_DROP      = -16'sd100;
    localparam logic signed [15:0] VEL_FAST_DROP = -16'sd200;
    localparam logic [6:0] W_DROP      = 7'd40;
    localparam logic [6:0] W_FAST_DROP = 7'd30;
    localparam logic [6:0] W_NEAR      = 7'd20;
    localparam logic [6:0] W_HISTORY   = 7'd30;

    // History state seen by the classifier
    typedef struct packed {
        logic               filled_next;
        logic signed [15:0] lookback_cm;
        logic               point_cloud;
    } hist_status_t;

    // History update from one classified item
    typedef struct packed {
        logic               present;
        logic signed [15:0] dist_cm;
        logic               point_cloud_next;
    } hist_update_t;

    // One result item
    typedef struct packed {
        logic [2:0]  posture;
        logic [6:0]  fall_score;
        logic [6:0]  movement_level;
        logic        alert_raised;
        logic        alert_verified;
        logic [15:0] impact_speed_cms;
        logic [1:0]  mode_request;
        logic [2:0]  occupants;
    } result_t;

endpackage

`default_nettype wire

### design/radar_fall_classifier.sv
// Radar fall classifier: one result item for each radar frame item.
// Path from input accept to result accept: input register, then result register.
// Throughput: 1 item per cycle while out_stall lets the result register move on, set by the single classify pass.
// The distance history is read and written in the same pass, so items follow back to back.
// Reset (rst_n, async low) clears valid flags, the distance ring, position, fill and mode
// flags, and loads the alert threshold with 70; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module radar_fall_classifier
    import rfc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic        [6:0]  cfg_wdata,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic        [7:0]  targets_seen,
    input  wire logic signed [15:0] target_distance_cm,
    input  wire logic signed [15:0] target_velocity_cms,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic             [2:0]  posture,
    output logic             [6:0]  fall_score,
    output logic             [6:0]  movement_level,
    output logic                    alert_raised,
    output logic                    alert_verified,
    output logic             [15:0] impact_speed_cms,
    output logic             [1:0]  mode_request,
    output logic             [2:0]  occupants
);

    logic [6:0]         thr_reg;
    logic               s1_valid_reg;
    logic [7:0]         s1_count_reg;
    logic signed [15:0] s1_dist_reg;
    logic signed [15:0] s1_vel_reg;
    logic               out_valid_reg;
    result_t            result_reg;
    result_t            result_next;
    hist_status_t       status;
    hist_update_t       update;
    logic               out_free;
    logic               s1_advance;
    logic               in_take;

    // Hold the alert threshold
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= THRESHOLD_RESET;
        else if (cfg_we)
            thr_reg <= cfg_wdata;
    end

    // Stall the input only when the input register cannot move on
    assign out_free   = !out_valid_reg || !out_stall;
    assign s1_advance = s1_valid_reg && out_free;
    assign in_stall   = s1_valid_reg && !out_free;
    assign in_take    = in_valid && !in_stall;

    // Capture the item in the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (!in_stall)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_count_reg <= targets_seen;
            s1_dist_reg  <= target_distance_cm;
            s1_vel_reg   <= target_velocity_cms;
        end
    end

    rfc_history u_history (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (s1_advance),
        .update  (update),
        .status  (status)
    );

    rfc_classify u_classify (
        .targets_seen        (s1_count_reg),
        .target_distance_cm  (s1_dist_reg),
        .target_velocity_cms (s1_vel_reg),
        .threshold           (thr_reg),
        .status              (status),
        .result              (result_next),
        .update              (update)
    );

    // Load the result register when it is free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
            result_reg <= result_next;
    end

    assign out_valid        = out_valid_reg;
    assign posture          = result_reg.posture;
    assign fall_score       = result_reg.fall_score;
    assign movement_level   = result_reg.movement_level;
    assign alert_raised     = result_reg.alert_raised;
    assign alert_verified   = result_reg.alert_verified;
    assign impact_speed_cms = result_reg.impact_speed_cms;
    assign mode_request     = result_reg.mode_request;
    assign occupants        = result_reg.occupants;

    // Input stalls only behind a held item
    `RFC_ASSERT(a_stall_has_item, clk, rst_n, in_stall |-> s1_valid_reg, "stall without item")
    // An absent frame carries no score and no speed
    `RFC_ASSERT(a_absent_quiet, clk, rst_n,
        (out_valid_reg && posture == POSTURE_ABSENT) |->
        (fall_score == 7'd0 && impact_speed_cms == 16'd0 && !alert_verified),
        "absent frame with score or speed")
    // The score never passes its clamp
    `RFC_ASSERT_NEVER(a_score_clamp, clk, rst_n,
        out_valid_reg && fall_score > SCORE_MAX, "fall score above clamp")
    // A verified alert implies a high score
    `RFC_ASSERT(a_verified_score, clk, rst_n,
        (out_valid_reg && alert_verified) |-> (fall_score > VERIFY_LEVEL),
        "verified alert with low score")

endmodule

`default_nettype wire

### design/rfc_history.sv
// Distance ring, ring position, fill flag and radar mode state.
`timescale 1ns / 1ps
`default_nettype none

module rfc_history
    import rfc_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         advance,
    input  wire hist_update_t update,
    output hist_status_t      status
);

    logic signed [15:0]    ring_reg [HIST_DEPTH];
    logic [HIST_IDX_W-1:0] pos_reg;
    logic [HIST_IDX_W-1:0] pos_next;
    logic [HIST_IDX_W-1:0] back_idx;
    logic                  filled_reg;
    logic                  filled_next;
    logic                  point_cloud_reg;

    // Wrap the position at the ring depth
    always_comb
    begin
        if (pos_reg == HIST_IDX_W'(HIST_DEPTH - 1))
            pos_next = '0;
        else
            pos_next = pos_reg + 1'b1;
        filled_next = filled_reg | (pos_next == '0);
    end

    // Pick the entry written two items before the current one
    always_comb
    begin
        if (pos_reg >= HIST_IDX_W'(HIST_BACK_OFS))
            back_idx = pos_reg - HIST_IDX_W'(HIST_BACK_OFS);
        else
            back_idx = pos_reg + HIST_IDX_W'(HIST_DEPTH - HIST_BACK_OFS);
    end

    assign status.filled_next = filled_next;
    assign status.lookback_cm = ring_reg[back_idx];
    assign status.point_cloud = point_cloud_reg;

    // Advance the history once per classified item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HIST_DEPTH; i++)
                ring_reg[i] <= '0;
            pos_reg         <= '0;
            filled_reg      <= 1'b0;
            point_cloud_reg <= 1'b0;
        end
        else if (advance)
        begin
            if (update.present)
                ring_reg[pos_reg] <= update.dist_cm;
            pos_reg         <= pos_next;
            filled_reg      <= filled_next;
            point_cloud_reg <= update.point_cloud_next;
        end
    end

endmodule

`default_nettype wire

### design/rfc_classify.sv
// Posture, fall score, movement level and mode request of one frame.
`timescale 1ns / 1ps
`default_nettype none

module rfc_classify
    import rfc_pkg::*;
(
    input  wire logic        [7:0]  targets_seen,
    input  wire logic signed [15:0] target_distance_cm,
    input  wire logic signed [15:0] target_velocity_cms,
    input  wire logic        [6:0]  threshold,
    input  wire hist_status_t       status,
    output result_t                 result,
    output hist_update_t            update
);

    logic        present;
    logic [2:0]  occupants;
    logic [15:0] speed;
    logic [2:0]  posture;
    logic [6:0]  score_raw;
    logic [6:0]  score;
    logic [6:0]  move;
    logic        dist_near;
    logic        history_hit;
    logic [1:0]  mode;
    logic        point_cloud_next;

    // Clamp the target count
    always_comb
    begin
        if (targets_seen > OCCUPANTS_MAX)
            occupants = OCCUPANTS_MAX[2:0];
        else
            occupants = targets_seen[2:0];
        present = (targets_seen != 8'd0);
    end

    // Take the magnitude; the most negative velocity maps to 32768
    assign speed = target_velocity_cms[15] ? (~target_velocity_cms + 16'd1)
                                           : target_velocity_cms;

    assign dist_near = (target_distance_cm < DIST_NEAR);

    // Classify posture from presence, velocity, distance and speed
    always_comb
    begin
        if (!present)
            posture = POSTURE_ABSENT;
        else if (target_velocity_cms < VEL_FALLING)
            posture = POSTURE_FALLING;
        else if (dist_near && speed < SPEED_LYING)
            posture = POSTURE_LYING;
        else if (target_distance_cm > DIST_MID && target_distance_cm < DIST_STAND_HI
                 && speed < SPEED_STAND)
            posture = POSTURE_STANDING;
        else if (target_distance_cm > DIST_SIT_LO && target_distance_cm < DIST_MID
                 && speed < SPEED_SIT)
            posture = POSTURE_SITTING;
        else
            posture = POSTURE_UNKNOWN;
    end

    // Sum the score contributions and clamp; an absent frame scores zero
    assign history_hit = status.filled_next && (status.lookback_cm > DIST_MID) && dist_near;

    always_comb
    begin
        score_raw = ((target_velocity_cms < VEL_DROP)      ? W_DROP      : 7'd0)
                  + ((target_velocity_cms < VEL_FAST_DROP) ? W_FAST_DROP : 7'd0)
                  + (dist_near                             ? W_NEAR      : 7'd0)
                  + (history_hit                           ? W_HISTORY   : 7'd0);
        if (!present)
            score = 7'd0;
        else if (score_raw > SCORE_MAX)
            score = SCORE_MAX;
        else
            score = score_raw;
    end

    // Halve the speed and clamp
    always_comb
    begin
        if (!present)
            move = 7'd0;
        else if (speed[15:1] > 15'(MOVE_MAX))
            move = MOVE_MAX;
        else
            move = speed[7:1];
    end

    // Request a mode change on presence edges
    always_comb
    begin
        mode             = MODE_NONE;
        point_cloud_next = status.point_cloud;
        if (present && !status.point_cloud)
        begin
            mode             = MODE_POINT;
            point_cloud_next = 1'b1;
        end
        else if (!present && status.point_cloud)
        begin
            mode             = MODE_PRESENCE;
            point_cloud_next = 1'b0;
        end
    end

    assign result.posture          = posture;
    assign result.fall_score       = score;
    assign result.movement_level   = move;
    assign result.alert_raised     = (score > threshold);
    assign result.alert_verified   = (score > VERIFY_LEVEL);
    assign result.impact_speed_cms = present ? speed : 16'd0;
    assign result.mode_request     = mode;
    assign result.occupants        = occupants;

    assign update.present          = present;
    assign update.dist_cm          = target_distance_cm;
    assign update.point_cloud_next = point_cloud_next;

endmodule

`default_nettype wire
